// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is active
`define EHT_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) expr) else $error(msg);

// Clocked check, also active during reset
`define EHT_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) expr) else $error(msg);

`endif

// ===== rtl/eht_pkg.sv =====
`timescale 1ns / 1ps

package eht_pkg;

    // Request kinds
    localparam logic [1:0] ACT_FIND   = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_QUERY  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Fixed field widths
    localparam int ACTION_W   = 2;
    localparam int DIR_SLOT_W = 6;
    localparam int STATUS_W   = 2;
    localparam int GD_OUT_W   = 3;
    localparam int BC_OUT_W   = 7;
    localparam int LD_OUT_W   = 3;
    localparam int CAP_W      = 4;
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIR_RD,
        OP_BKT_RD,
        OP_MASK,
        OP_KEY_RD,
        OP_KEY_CMP,
        OP_HIT,
        OP_PUT,
        OP_DBL_RD,
        OP_DBL_WR,
        OP_GROW,
        OP_SPLIT,
        OP_RP_RD,
        OP_RP_WR,
        OP_MV_RD,
        OP_MV_WR,
        OP_FIN_OLD,
        OP_FIN_NEW,
        OP_RESULT
    } op_t;

    // Kind of result word to build
    typedef enum logic [2:0] {
        RES_OK,
        RES_FOUND,
        RES_HIT,
        RES_MISS,
        RES_FULL,
        RES_QUERY
    } res_t;

    typedef struct packed {
        op_t  op;
        res_t res;
        logic clr_i;
        logic inc_i;
    } cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                loop;
        logic                match;
        logic                scan_last;
        logic                room;
        logic                bkt_lim;
        logic                need_dbl;
        logic                gd_max;
        logic                dbl_last;
        logic                rp_last;
        logic                out_free;
    } sts_t;

endpackage

// ===== rtl/eht_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eht_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  eht_pkg::sts_t sts,
    output eht_pkg::cmd_t cmd
);

    typedef enum logic [19:0] {
        S_IDLE    = 20'h00001,
        S_DIR     = 20'h00002,
        S_BKT     = 20'h00004,
        S_MASK    = 20'h00008,
        S_KRD     = 20'h00010,
        S_KCMP    = 20'h00020,
        S_HIT     = 20'h00040,
        S_INS     = 20'h00080,
        S_PUT     = 20'h00100,
        S_DBL_RD  = 20'h00200,
        S_DBL_WR  = 20'h00400,
        S_GROW    = 20'h00800,
        S_SPLIT   = 20'h01000,
        S_RP_RD   = 20'h02000,
        S_RP_WR   = 20'h04000,
        S_MV_RD   = 20'h08000,
        S_MV_WR   = 20'h10000,
        S_FIN_OLD = 20'h20000,
        S_FIN_NEW = 20'h40000,
        S_DONE    = 20'h80000
    } state_t;

    state_t        state_reg, state_next;
    eht_pkg::res_t res_reg, res_next;

    // Hold state and pending result kind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= eht_pkg::RES_OK;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    // Sequence the datapath
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd.op     = eht_pkg::OP_NONE;
        cmd.res    = res_reg;
        cmd.clr_i  = 1'b0;
        cmd.inc_i  = 1'b0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = eht_pkg::OP_LOAD;
                    state_next = S_DIR;
                end
            end
            S_DIR:
            begin
                cmd.op     = eht_pkg::OP_DIR_RD;
                state_next = S_BKT;
            end
            S_BKT:
            begin
                cmd.op     = eht_pkg::OP_BKT_RD;
                state_next = S_MASK;
            end
            S_MASK:
            begin
                cmd.op    = eht_pkg::OP_MASK;
                cmd.clr_i = 1'b1;
                if (sts.action == eht_pkg::ACT_QUERY)
                begin
                    res_next   = eht_pkg::RES_QUERY;
                    state_next = S_DONE;
                end
                else if (sts.loop)
                    state_next = S_INS;
                else
                    state_next = S_KRD;
            end
            S_KRD:
            begin
                cmd.op     = eht_pkg::OP_KEY_RD;
                state_next = S_KCMP;
            end
            S_KCMP:
            begin
                cmd.op    = eht_pkg::OP_KEY_CMP;
                cmd.inc_i = 1'b1;
                if (sts.match)
                begin
                    if (sts.action == eht_pkg::ACT_FIND)
                    begin
                        res_next   = eht_pkg::RES_FOUND;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_HIT;
                end
                else if (sts.scan_last)
                begin
                    if (sts.action == eht_pkg::ACT_INSERT)
                        state_next = S_INS;
                    else
                    begin
                        res_next   = eht_pkg::RES_MISS;
                        state_next = S_DONE;
                    end
                end
                else
                    state_next = S_KRD;
            end
            S_HIT:
            begin
                cmd.op     = eht_pkg::OP_HIT;
                res_next   = eht_pkg::RES_HIT;
                state_next = S_DONE;
            end
            S_INS:
            begin
                if (sts.room)
                    state_next = S_PUT;
                else if (sts.bkt_lim || (sts.need_dbl && sts.gd_max))
                begin
                    res_next   = eht_pkg::RES_FULL;
                    state_next = S_DONE;
                end
                else if (sts.need_dbl)
                begin
                    cmd.clr_i  = 1'b1;
                    state_next = S_DBL_RD;
                end
                else
                    state_next = S_SPLIT;
            end
            S_PUT:
            begin
                cmd.op     = eht_pkg::OP_PUT;
                res_next   = eht_pkg::RES_OK;
                state_next = S_DONE;
            end
            S_DBL_RD:
            begin
                cmd.op     = eht_pkg::OP_DBL_RD;
                state_next = S_DBL_WR;
            end
            S_DBL_WR:
            begin
                cmd.op     = eht_pkg::OP_DBL_WR;
                cmd.inc_i  = 1'b1;
                state_next = sts.dbl_last ? S_GROW : S_DBL_RD;
            end
            S_GROW:
            begin
                cmd.op     = eht_pkg::OP_GROW;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                cmd.op     = eht_pkg::OP_SPLIT;
                cmd.clr_i  = 1'b1;
                state_next = S_RP_RD;
            end
            S_RP_RD:
            begin
                cmd.op     = eht_pkg::OP_RP_RD;
                state_next = S_RP_WR;
            end
            S_RP_WR:
            begin
                cmd.op    = eht_pkg::OP_RP_WR;
                cmd.inc_i = 1'b1;
                if (sts.rp_last)
                begin
                    cmd.clr_i  = 1'b1;
                    state_next = S_MV_RD;
                end
                else
                    state_next = S_RP_RD;
            end
            S_MV_RD:
            begin
                cmd.op     = eht_pkg::OP_MV_RD;
                state_next = S_MV_WR;
            end
            S_MV_WR:
            begin
                cmd.op    = eht_pkg::OP_MV_WR;
                cmd.inc_i = 1'b1;
                if (sts.scan_last)
                begin
                    cmd.clr_i  = 1'b1;
                    state_next = S_FIN_OLD;
                end
                else
                    state_next = S_MV_RD;
            end
            S_FIN_OLD:
            begin
                cmd.op     = eht_pkg::OP_FIN_OLD;
                state_next = S_FIN_NEW;
            end
            S_FIN_NEW:
            begin
                cmd.op     = eht_pkg::OP_FIN_NEW;
                state_next = S_DIR;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = eht_pkg::OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `EHT_ASSERT(a_result_has_room, (cmd.op == eht_pkg::OP_RESULT) |-> sts.out_free, "result word would overwrite an untaken word")
    `EHT_ASSERT(a_load_only_idle, (cmd.op == eht_pkg::OP_LOAD) |=> (state_reg == S_DIR), "request load did not start a lookup")

endmodule

// ===== rtl/eht_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eht_datapath #(
    parameter int MAX_GLOBAL_DEPTH  = 6,
    parameter int MAX_BUCKETS       = 64,
    parameter int BUCKET_SLOTS      = 8,
    parameter int INIT_GLOBAL_DEPTH = 0,
    parameter int KEY_WIDTH         = 32,
    parameter int VALUE_WIDTH       = 32,
    parameter int IN_W              = 72,
    parameter int OUT_W             = 48
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  eht_pkg::cmd_t             cmd,
    output eht_pkg::sts_t             sts,
    input  logic [IN_W-1:0]           in_data,
    input  logic [eht_pkg::ACTION_W-1:0] in_action,
    input  logic                      cfg_we,
    input  logic [eht_pkg::CAP_W-1:0] cfg_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [OUT_W-1:0]          out_data
);

    localparam int DIR_N = 1 << MAX_GLOBAL_DEPTH;
    localparam int DW    = MAX_GLOBAL_DEPTH;
    localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int GW    = $clog2(MAX_GLOBAL_DEPTH + 1);
    localparam int CW    = $clog2(MAX_BUCKETS + 1);
    localparam int SW    = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
    localparam int PW    = $clog2(BUCKET_SLOTS + 1);
    localparam int NS    = MAX_BUCKETS * BUCKET_SLOTS;
    localparam int AW    = (NS > 1) ? $clog2(NS) : 1;
    localparam int IW    = (DW > SW) ? DW : SW;
    localparam int RW    = eht_pkg::STATUS_W + VALUE_WIDTH + 1 + eht_pkg::GD_OUT_W
                           + eht_pkg::BC_OUT_W + eht_pkg::LD_OUT_W;

    // Request and table registers
    logic [eht_pkg::ACTION_W-1:0]   act_reg;
    logic [KEY_WIDTH-1:0]           key_reg;
    logic [VALUE_WIDTH-1:0]         val_reg;
    logic [eht_pkg::DIR_SLOT_W-1:0] slot_reg;
    logic [GW-1:0]                  gd_reg;
    logic [CW-1:0]                  bused_reg;
    logic [eht_pkg::CAP_W-1:0]      cap_reg;
    logic [BW-1:0]                  b_reg, nb_reg;
    logic [GW-1:0]                  ld_reg;
    logic [BUCKET_SLOTS-1:0]        vmask_reg, nmask_reg;
    logic [IW-1:0]                  i_reg;
    logic [SW-1:0]                  k_reg, pos_reg;
    logic [VALUE_WIDTH-1:0]         fval_reg;
    logic                           loop_reg;
    logic                           ov_reg;
    logic [OUT_W-1:0]               odata_reg;

    // Memories and their entry-valid flops
    logic [BW-1:0]           dir_mem [DIR_N];
    logic [DIR_N-1:0]        dir_ok_reg;
    logic [BW-1:0]           dir_q;
    logic [GW-1:0]           dep_mem [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0]  dep_ok_reg;
    logic [GW-1:0]           dep_q;
    logic [BUCKET_SLOTS-1:0] vld_mem [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0]  vld_ok_reg;
    logic [BUCKET_SLOTS-1:0] vld_q;
    logic [KEY_WIDTH-1:0]    key_mem [NS];
    logic [VALUE_WIDTH-1:0]  val_mem [NS];
    logic [KEY_WIDTH-1:0]    key_q;
    logic [VALUE_WIDTH-1:0]  valm_q;

    // Derived values
    logic [DW-1:0]        dmask;
    logic [DW:0]          half;
    logic [DW-1:0]        i_dir;
    logic [SW-1:0]        i_slot;
    logic [PW-1:0]        cnt;
    logic [PW-1:0]        cap_eff;
    logic [SW-1:0]        free_slot;
    logic                 key_bit;
    logic                 dir_bit;
    logic                 match;
    logic                 qok;
    logic [GW-1:0]        ld_inc;

    // Memory ports
    logic [DW-1:0]           dir_ra, dir_wa;
    logic                    dir_we;
    logic [BW-1:0]           dir_wd;
    logic [BW-1:0]           bk_ra;
    logic                    dep_we, vld_we;
    logic [BW-1:0]           bk_wa;
    logic [GW-1:0]           dep_wd;
    logic [BUCKET_SLOTS-1:0] vld_wd;
    logic [AW-1:0]           sl_ra, sl_wa;
    logic                    key_we, val_we;
    logic [KEY_WIDTH-1:0]    key_wd;
    logic [VALUE_WIDTH-1:0]  val_wd;

    // Result fields
    logic                           r_hit;
    logic [VALUE_WIDTH-1:0]         r_vout;
    logic [eht_pkg::STATUS_W-1:0]   r_status;
    logic [eht_pkg::LD_OUT_W-1:0]   r_ld;
    logic [GW-1:0]                  gd_after;
    logic [CW-1:0]                  bc_after;

    assign dmask   = DW'(((DW + 1)'(1) << gd_reg) - (DW + 1)'(1));
    assign half    = (DW + 1)'(1) << gd_reg;
    assign i_dir   = i_reg[DW-1:0];
    assign i_slot  = i_reg[SW-1:0];
    assign ld_inc  = ld_reg + GW'(1);
    assign key_bit = |(key_q & (KEY_WIDTH'(1) << ld_reg));
    assign dir_bit = |(i_dir & (DW'(1) << ld_reg));
    assign match   = vmask_reg[i_slot] && (key_q == key_reg);
    assign qok     = (32'(slot_reg) <= 32'(dmask));

    // Count filled slots and find the first free one
    always_comb
    begin
        cnt       = '0;
        free_slot = '0;
        for (int j = 0; j < BUCKET_SLOTS; j++)
            cnt = cnt + PW'(vmask_reg[j]);
        for (int j = BUCKET_SLOTS - 1; j >= 0; j--)
            if (!vmask_reg[j])
                free_slot = SW'(j);
    end

    // Clamp the capacity setting
    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = PW'(1);
        else if (32'(cap_reg) > BUCKET_SLOTS)
            cap_eff = PW'(BUCKET_SLOTS);
        else
            cap_eff = PW'(cap_reg);
    end

    // Status toward the controller
    always_comb
    begin
        sts.action    = act_reg;
        sts.loop      = loop_reg;
        sts.match     = match;
        sts.scan_last = (i_reg == IW'(BUCKET_SLOTS - 1));
        sts.room      = (cnt < cap_eff);
        sts.bkt_lim   = (bused_reg >= CW'(MAX_BUCKETS));
        sts.need_dbl  = (ld_reg >= gd_reg);
        sts.gd_max    = (gd_reg >= GW'(MAX_GLOBAL_DEPTH));
        sts.dbl_last  = (((DW + 1)'(i_dir) + (DW + 1)'(1)) == half);
        sts.rp_last   = (i_dir == dmask);
        sts.out_free  = !ov_reg || out_ready;
    end

    // Directory port
    always_comb
    begin
        dir_ra = '0;
        dir_we = 1'b0;
        dir_wa = i_dir;
        dir_wd = dir_q;
        case (cmd.op)
            eht_pkg::OP_DIR_RD:
                dir_ra = (act_reg == eht_pkg::ACT_QUERY) ? DW'(slot_reg)
                                                         : (key_reg[DW-1:0] & dmask);
            eht_pkg::OP_DBL_RD,
            eht_pkg::OP_RP_RD:
                dir_ra = i_dir;
            eht_pkg::OP_DBL_WR:
            begin
                dir_we = 1'b1;
                dir_wa = DW'((DW + 1)'(i_dir) + half);
            end
            eht_pkg::OP_RP_WR:
            begin
                dir_we = (dir_q == b_reg) && dir_bit;
                dir_wd = nb_reg;
            end
            default:
            begin
                dir_ra = '0;
            end
        endcase
    end

    // Bucket depth and valid-row ports
    always_comb
    begin
        bk_ra  = dir_q;
        bk_wa  = b_reg;
        dep_we = 1'b0;
        vld_we = 1'b0;
        dep_wd = ld_inc;
        vld_wd = vmask_reg;
        case (cmd.op)
            eht_pkg::OP_HIT:
            begin
                vld_we = (act_reg == eht_pkg::ACT_REMOVE);
                vld_wd = vmask_reg & ~(BUCKET_SLOTS'(1) << pos_reg);
            end
            eht_pkg::OP_PUT:
            begin
                vld_we = 1'b1;
                vld_wd = vmask_reg | (BUCKET_SLOTS'(1) << free_slot);
            end
            eht_pkg::OP_FIN_OLD:
            begin
                vld_we = 1'b1;
                dep_we = 1'b1;
            end
            eht_pkg::OP_FIN_NEW:
            begin
                bk_wa  = nb_reg;
                vld_we = 1'b1;
                dep_we = 1'b1;
                vld_wd = nmask_reg;
            end
            default:
            begin
                vld_we = 1'b0;
            end
        endcase
    end

    // Key and value ports
    always_comb
    begin
        sl_ra  = AW'(b_reg) * AW'(BUCKET_SLOTS) + AW'(i_slot);
        sl_wa  = AW'(b_reg) * AW'(BUCKET_SLOTS) + AW'(pos_reg);
        key_we = 1'b0;
        val_we = 1'b0;
        key_wd = key_reg;
        val_wd = val_reg;
        case (cmd.op)
            eht_pkg::OP_HIT:
                val_we = (act_reg == eht_pkg::ACT_INSERT);
            eht_pkg::OP_PUT:
            begin
                sl_wa  = AW'(b_reg) * AW'(BUCKET_SLOTS) + AW'(free_slot);
                key_we = 1'b1;
                val_we = 1'b1;
            end
            eht_pkg::OP_MV_WR:
            begin
                sl_wa  = AW'(nb_reg) * AW'(BUCKET_SLOTS) + AW'(k_reg);
                key_we = vmask_reg[i_slot] && key_bit;
                val_we = vmask_reg[i_slot] && key_bit;
                key_wd = key_q;
                val_wd = valm_q;
            end
            default:
            begin
                key_we = 1'b0;
            end
        endcase
    end

    // Memory arrays
    always_ff @(posedge clk)
    begin
        if (dir_we)
            dir_mem[dir_wa] <= dir_wd;
        dir_q <= dir_ok_reg[dir_ra] ? dir_mem[dir_ra] : BW'(dir_ra);
        if (dep_we)
            dep_mem[bk_wa] <= dep_wd;
        dep_q <= dep_ok_reg[bk_ra] ? dep_mem[bk_ra] : GW'(INIT_GLOBAL_DEPTH);
        if (vld_we)
            vld_mem[bk_wa] <= vld_wd;
        vld_q <= vld_ok_reg[bk_ra] ? vld_mem[bk_ra] : '0;
        if (key_we)
            key_mem[sl_wa] <= key_wd;
        if (val_we)
            val_mem[sl_wa] <= val_wd;
        key_q  <= key_mem[sl_ra];
        valm_q <= val_mem[sl_ra];
    end

    // Mark entries once written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_ok_reg <= '0;
            dep_ok_reg <= '0;
            vld_ok_reg <= '0;
        end
        else
        begin
            if (dir_we)
                dir_ok_reg[dir_wa] <= 1'b1;
            if (dep_we)
                dep_ok_reg[bk_wa] <= 1'b1;
            if (vld_we)
                vld_ok_reg[bk_wa] <= 1'b1;
        end
    end

    // Build the result word
    always_comb
    begin
        r_hit    = 1'b0;
        r_vout   = '0;
        r_status = eht_pkg::ST_OK;
        r_ld     = '0;
        case (cmd.res)
            eht_pkg::RES_FOUND:
            begin
                r_hit  = 1'b1;
                r_vout = fval_reg;
            end
            eht_pkg::RES_HIT:
                r_hit = 1'b1;
            eht_pkg::RES_MISS:
                r_status = eht_pkg::ST_MISS;
            eht_pkg::RES_FULL:
                r_status = eht_pkg::ST_FULL;
            eht_pkg::RES_QUERY:
            begin
                if (qok)
                    r_ld = eht_pkg::LD_OUT_W'(ld_reg);
                else
                    r_status = eht_pkg::ST_FULL;
            end
            default:
                r_status = eht_pkg::ST_OK;
        endcase
        gd_after = gd_reg;
        bc_after = bused_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gd_reg    <= GW'(INIT_GLOBAL_DEPTH);
            bused_reg <= CW'(1 << INIT_GLOBAL_DEPTH);
            cap_reg   <= eht_pkg::CAP_RESET;
            loop_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            i_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_data;
            if (cmd.clr_i)
                i_reg <= '0;
            else if (cmd.inc_i)
                i_reg <= i_reg + IW'(1);
            case (cmd.op)
                eht_pkg::OP_LOAD:    loop_reg  <= 1'b0;
                eht_pkg::OP_FIN_NEW: loop_reg  <= 1'b1;
                eht_pkg::OP_GROW:    gd_reg    <= gd_reg + GW'(1);
                eht_pkg::OP_SPLIT:   bused_reg <= bused_reg + CW'(1);
                default:             loop_reg  <= loop_reg;
            endcase
            if (cmd.op == eht_pkg::OP_RESULT)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            eht_pkg::OP_LOAD:
            begin
                act_reg  <= in_action;
                key_reg  <= in_data[KEY_WIDTH-1:0];
                val_reg  <= in_data[KEY_WIDTH +: VALUE_WIDTH];
                slot_reg <= in_data[KEY_WIDTH + VALUE_WIDTH +: eht_pkg::DIR_SLOT_W];
            end
            eht_pkg::OP_BKT_RD:
                b_reg <= dir_q;
            eht_pkg::OP_MASK:
            begin
                vmask_reg <= vld_q;
                ld_reg    <= dep_q;
            end
            eht_pkg::OP_KEY_CMP:
            begin
                if (match)
                begin
                    pos_reg  <= i_slot;
                    fval_reg <= valm_q;
                end
            end
            eht_pkg::OP_SPLIT:
            begin
                nb_reg    <= BW'(bused_reg);
                nmask_reg <= '0;
                k_reg     <= '0;
            end
            eht_pkg::OP_MV_WR:
            begin
                if (vmask_reg[i_slot] && key_bit)
                begin
                    vmask_reg[i_slot] <= 1'b0;
                    nmask_reg[k_reg]  <= 1'b1;
                    k_reg             <= k_reg + SW'(1);
                end
            end
            eht_pkg::OP_RESULT:
                odata_reg <= OUT_W'({r_ld, eht_pkg::BC_OUT_W'(bc_after),
                                     eht_pkg::GD_OUT_W'(gd_after), r_status, r_vout, r_hit});
            default:
                act_reg <= act_reg;
        endcase
    end

    assign out_valid = ov_reg;
    assign out_data  = odata_reg;

    `EHT_ASSERT(a_bucket_bound, bused_reg <= CW'(MAX_BUCKETS), "bucket count beyond limit")
    `EHT_ASSERT(a_depth_bound, gd_reg <= GW'(MAX_GLOBAL_DEPTH), "global depth beyond limit")
    `EHT_ASSERT(a_split_count, (cmd.op == eht_pkg::OP_SPLIT) |=> (bused_reg == $past(bused_reg) + CW'(1)), "split did not take a bucket")
    `EHT_ASSERT_ALWAYS(a_word_width, RW <= OUT_W, "result word wider than port")

endmodule

// ===== rtl/extendible_hash_table_top.sv =====
// A find or remove reads the directory entry and the bucket, then scans the slots,
// reading each key from the key memory into a register and comparing it before the
// next. An insert that splits may first double the directory, then repoints directory
// entries and moves keys to the new bucket; a query skips the scan. One request at a time.
// Reset (rst_n low, asynchronous) empties the table at once through per-entry valid
// flops: no clearing pass, the block takes requests as soon as reset is released.
`timescale 1ns / 1ps

module extendible_hash_table_top #(
    parameter int MAX_GLOBAL_DEPTH  = 6,
    parameter int MAX_BUCKETS       = 64,
    parameter int BUCKET_SLOTS      = 8,
    parameter int INIT_GLOBAL_DEPTH = 0,
    parameter int KEY_WIDTH         = 32,
    parameter int VALUE_WIDTH       = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // key, value_in, dir_slot
    input  logic [((KEY_WIDTH + VALUE_WIDTH + 6 + 7) / 8) * 8 - 1:0] s_tdata,
    // action
    input  logic [eht_pkg::ACTION_W-1:0]         s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // hit, value_out, status, global_depth, bucket_count, local_depth
    output logic [((VALUE_WIDTH + 16 + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [eht_pkg::CAP_W-1:0]            cfg_wr_data
);

    localparam int IN_W  = ((KEY_WIDTH + VALUE_WIDTH + 6 + 7) / 8) * 8;
    localparam int OUT_W = ((VALUE_WIDTH + 16 + 7) / 8) * 8;

    eht_pkg::cmd_t cmd;
    eht_pkg::sts_t sts;

    // Sequence each request
    eht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the table and the result word
    eht_datapath #(
        .MAX_GLOBAL_DEPTH  (MAX_GLOBAL_DEPTH),
        .MAX_BUCKETS       (MAX_BUCKETS),
        .BUCKET_SLOTS      (BUCKET_SLOTS),
        .INIT_GLOBAL_DEPTH (INIT_GLOBAL_DEPTH),
        .KEY_WIDTH         (KEY_WIDTH),
        .VALUE_WIDTH       (VALUE_WIDTH),
        .IN_W              (IN_W),
        .OUT_W             (OUT_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .in_action (s_tuser),
        .cfg_we    (cfg_wr_en),
        .cfg_data  (cfg_wr_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
